// ===== rtl/wrt_pkg.sv =====
// Package for the work/relax timer: shared constants, phase codes,
// controller command and status structs. No dependencies.
`default_nettype none

package wrt_pkg;

    localparam int unsigned BUTTON_PERIOD  = 5;
    localparam int unsigned DISPLAY_PERIOD = 100;
    localparam int unsigned INTEGRATOR_MAX = 5;
    localparam int unsigned HOLD_LIMIT     = 60;
    localparam int unsigned LED_COUNT      = 7;

    localparam int unsigned TICK_W   = 24;
    localparam int unsigned BDIV_W   = $clog2(BUTTON_PERIOD + 1);
    localparam int unsigned DDIV_W   = $clog2(DISPLAY_PERIOD + 1);
    localparam int unsigned INTEG_W  = $clog2(INTEGRATOR_MAX + 1);
    localparam int unsigned HOLD_W   = 16;
    localparam int unsigned STEP_W   = $clog2(LED_COUNT);
    localparam int unsigned PCT_W    = 7;
    localparam int unsigned PROD_W   = TICK_W + PCT_W;
    localparam int unsigned QUO_BITS = PCT_W;
    localparam int unsigned QCNT_W   = $clog2(QUO_BITS);
    localparam int unsigned SEG_SIZE = 100 / LED_COUNT;
    localparam int unsigned CFG_IDX_W = 1;

    localparam logic [TICK_W-1:0] WORK_TICKS_RST  = TICK_W'(90000);
    localparam logic [TICK_W-1:0] RELAX_TICKS_RST = TICK_W'(30000);
    localparam logic [TICK_W-1:0] TICK_MAX        = {TICK_W{1'b1}};
    localparam logic [HOLD_W-1:0] HOLD_MAX        = {HOLD_W{1'b1}};
    localparam logic [PCT_W-1:0]  PCT_FULL        = PCT_W'(100);

    localparam logic [CFG_IDX_W-1:0] REG_WORK_TICKS  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_RELAX_TICKS = 1'b1;

    typedef enum logic [2:0] {
        PH_WORK      = 3'd0,
        PH_WORK_ON   = 3'd1,
        PH_WORK_OFF  = 3'd2,
        PH_RELAX     = 3'd3,
        PH_RELAX_ON  = 3'd4,
        PH_RELAX_OFF = 3'd5
    } t_phase;

    typedef enum logic [1:0] {
        EV_NONE     = 2'd0,
        EV_PRESSED  = 2'd1,
        EV_HELD     = 2'd2,
        EV_RELEASED = 2'd3
    } t_event;

    typedef struct packed {
        logic step;
        logic load_mul;
        logic div_init;
        logic div_step;
        logic bar_apply;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic need_div;
        logic div_last;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

// ===== rtl/wrt_in_if.sv =====
// Input channel of the work/relax timer: one beat per 10 ms tick.
// Carries the raw button level. No dependencies.
`default_nettype none

interface wrt_in_if;
    logic valid;
    logic ready;
    logic button_level;

    modport source (output valid, output button_level, input ready);
    modport sink   (input valid, input button_level, output ready);
endinterface

`default_nettype wire

// ===== rtl/wrt_out_if.sv =====
// Result channel of the work/relax timer: LED bars, buzzer, phase and events.
// No dependencies.
`default_nettype none

interface wrt_out_if;
    logic       valid;
    logic       ready;
    logic [6:0] work_leds;
    logic [6:0] relax_leds;
    logic       buzzer_on;
    logic [2:0] phase_now;
    logic [1:0] button_event;
    logic       sleep_enter;

    modport source (output valid, output work_leds, output relax_leds, output buzzer_on,
                    output phase_now, output button_event, output sleep_enter,
                    input ready);
    modport sink   (input valid, input work_leds, input relax_leds, input buzzer_on,
                    input phase_now, input button_event, input sleep_enter,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/work_relax_timer_with_debounce.sv =====
// Top level of the work/relax timer with button debounce.
// Depends on wrt_pkg, wrt_in_if, wrt_out_if, wrt_ctrl and wrt_dpath.
//
//   channel   dir  payload                                  beat
//   i_btn     in   button_level                             one per 10 ms tick
//   o_res     out  work_leds relax_leds buzzer_on           one per input beat
//                  phase_now button_event sleep_enter
//   i_cfg_*   in   work_ticks (0), relax_ticks (1)          write when i_cfg_we
//
// One input beat at a time. Each beat passes the check state and then emit, which
// loads the result register once it frees; when a progress bar refresh falls on the
// tick, product load, the bit-serial percentage divider and the bar update come
// between them. Reset is synchronous.
// A stalled result holds in the output register; the next beat is taken
// meanwhile and its result waits until the register frees.
`default_nettype none

module work_relax_timer_with_debounce (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_cfg_we,
    input  wire  [wrt_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  wire  [wrt_pkg::TICK_W-1:0]          i_cfg_data,
    wrt_in_if.sink                              i_btn,
    wrt_out_if.source                           o_res
);

    wrt_pkg::t_cmd cmd;
    wrt_pkg::t_sts sts;

    wrt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_btn.valid),
        .o_in_ready (i_btn.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    wrt_dpath u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_button_level (i_btn.button_level),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .o_res          (o_res)
    );

endmodule

`default_nettype wire

// ===== rtl/wrt_ctrl.sv =====
// Controller of the work/relax timer: sequences tick update, bar division,
// bar update and result load. Depends on wrt_pkg.
`default_nettype none

module wrt_ctrl (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_in_valid,
    output logic           o_in_ready,
    input  wrt_pkg::t_sts  i_sts,
    output wrt_pkg::t_cmd  o_cmd
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_CHECK = 6'b000010,
        S_PREP  = 6'b000100,
        S_DIV   = 6'b001000,
        S_BAR   = 6'b010000,
        S_EMIT  = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.step = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_sts.need_div) begin
                    o_cmd.load_mul = 1'b1;
                    n_state        = S_PREP;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_PREP: begin
                o_cmd.div_init = 1'b1;
                n_state        = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_BAR;
                end
            end
            S_BAR: begin
                o_cmd.bar_apply = 1'b1;
                n_state         = S_EMIT;
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/wrt_dpath.sv =====
// Datapath of the work/relax timer: tick state, config registers, bar divider
// and result register. Depends on wrt_pkg and wrt_out_if.
`default_nettype none

module wrt_dpath (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_cfg_we,
    input  wire  [wrt_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  wire  [wrt_pkg::TICK_W-1:0]          i_cfg_data,
    input  wire                                 i_button_level,
    input  wrt_pkg::t_cmd                       i_cmd,
    output wrt_pkg::t_sts                       o_sts,
    wrt_out_if.source                           o_res
);

    localparam logic [wrt_pkg::LED_COUNT-1:0] BAR_FULL = {wrt_pkg::LED_COUNT{1'b1}};

    // configuration
    logic [wrt_pkg::TICK_W-1:0] r_work_ticks;
    logic [wrt_pkg::TICK_W-1:0] r_relax_ticks;

    // tick state
    wrt_pkg::t_phase                r_phase,   n_phase;
    logic [wrt_pkg::TICK_W-1:0]     r_elapsed, n_elapsed;
    logic [wrt_pkg::BDIV_W-1:0]     r_bdiv,    n_bdiv;
    logic [wrt_pkg::DDIV_W-1:0]     r_ddiv,    n_ddiv;
    logic [wrt_pkg::INTEG_W-1:0]    r_integ,   n_integ;
    logic                           r_pressed, n_pressed;
    logic [wrt_pkg::HOLD_W-1:0]     r_hold,    n_hold;
    logic                           r_sleeping, n_sleeping;
    logic [wrt_pkg::LED_COUNT-1:0]  r_work_bar, n_work_bar;
    logic [wrt_pkg::LED_COUNT-1:0]  r_relax_bar, n_relax_bar;
    logic                           r_buzzer,  n_buzzer;
    logic                           r_halted,  n_halted;
    wrt_pkg::t_event                r_event,   n_event;
    logic                           r_enter,   n_enter;
    logic                           r_need_div, n_need_div;

    // divider
    logic [wrt_pkg::PROD_W-1:0]     r_prod;
    logic [wrt_pkg::TICK_W:0]       r_rem;
    logic [wrt_pkg::QUO_BITS-1:0]   r_quo;
    logic [wrt_pkg::QCNT_W-1:0]     r_qcnt;

    // result register
    logic r_out_valid;

    logic [wrt_pkg::TICK_W-1:0] period;
    logic [wrt_pkg::TICK_W-1:0] el_inc;
    logic [wrt_pkg::TICK_W-1:0] per_a;
    logic [wrt_pkg::BDIV_W-1:0] bdiv_inc;
    logic [wrt_pkg::DDIV_W-1:0] ddiv_inc;
    logic [wrt_pkg::TICK_W:0]   trial;
    logic                       trial_ge;
    logic [wrt_pkg::PCT_W-1:0]  pct;
    logic [wrt_pkg::PCT_W-1:0]  pct_m1;
    logic [wrt_pkg::STEP_W-1:0] step;
    logic [wrt_pkg::LED_COUNT-1:0] bar_src;
    logic [wrt_pkg::LED_COUNT-1:0] bar_new;

    assign period = (r_phase <= wrt_pkg::PH_WORK_OFF) ? r_work_ticks : r_relax_ticks;

    // tick update
    always_comb begin
        n_phase     = r_phase;
        n_elapsed   = r_elapsed;
        n_bdiv      = r_bdiv;
        n_ddiv      = r_ddiv;
        n_integ     = r_integ;
        n_pressed   = r_pressed;
        n_hold      = r_hold;
        n_sleeping  = r_sleeping;
        n_work_bar  = r_work_bar;
        n_relax_bar = r_relax_bar;
        n_buzzer    = r_buzzer;
        n_halted    = r_halted;
        n_event     = wrt_pkg::EV_NONE;
        n_enter     = 1'b0;
        n_need_div  = 1'b0;
        el_inc      = (r_elapsed < wrt_pkg::TICK_MAX) ? r_elapsed + 1'b1 : r_elapsed;
        per_a       = period;
        bdiv_inc    = r_bdiv + 1'b1;
        ddiv_inc    = r_ddiv + 1'b1;
        if (!r_halted) begin
            n_elapsed = el_inc;
            if (el_inc >= per_a) begin
                n_elapsed = '0;
                if (!r_sleeping) begin
                    if (r_phase == wrt_pkg::PH_WORK) begin
                        n_phase = wrt_pkg::PH_WORK_ON;
                    end else if (r_phase == wrt_pkg::PH_RELAX) begin
                        n_phase = wrt_pkg::PH_RELAX_ON;
                    end
                end
            end

            n_bdiv = bdiv_inc;
            if (bdiv_inc >= wrt_pkg::BDIV_W'(wrt_pkg::BUTTON_PERIOD)) begin
                n_bdiv = '0;
                if (r_integ == wrt_pkg::INTEG_W'(wrt_pkg::INTEGRATOR_MAX)) begin
                    n_event   = r_pressed ? wrt_pkg::EV_HELD : wrt_pkg::EV_PRESSED;
                    n_hold    = (r_hold < wrt_pkg::HOLD_MAX) ? r_hold + 1'b1 : r_hold;
                    n_pressed = 1'b1;
                end else if (r_integ == '0) begin
                    n_event   = r_pressed ? wrt_pkg::EV_RELEASED : wrt_pkg::EV_NONE;
                    n_hold    = '0;
                    n_pressed = 1'b0;
                end
            end

            if (n_event == wrt_pkg::EV_RELEASED && r_sleeping) begin
                n_halted = 1'b1;
                n_enter  = 1'b1;
            end else begin
                if (n_event == wrt_pkg::EV_HELD &&
                    n_hold > wrt_pkg::HOLD_W'(wrt_pkg::HOLD_LIMIT)) begin
                    n_work_bar  = '0;
                    n_relax_bar = '0;
                    n_buzzer    = 1'b0;
                    n_sleeping  = 1'b1;
                end
                if (n_event == wrt_pkg::EV_PRESSED) begin
                    if (n_phase == wrt_pkg::PH_WORK_ON || n_phase == wrt_pkg::PH_WORK_OFF) begin
                        n_buzzer  = 1'b0;
                        n_elapsed = '0;
                        n_phase   = wrt_pkg::PH_RELAX;
                    end else if (n_phase == wrt_pkg::PH_RELAX_ON ||
                                 n_phase == wrt_pkg::PH_RELAX_OFF) begin
                        n_buzzer  = 1'b0;
                        n_elapsed = '0;
                        n_phase   = wrt_pkg::PH_WORK;
                    end
                end

                n_ddiv = ddiv_inc;
                if (ddiv_inc >= wrt_pkg::DDIV_W'(wrt_pkg::DISPLAY_PERIOD)) begin
                    n_ddiv = '0;
                    if (!n_sleeping) begin
                        unique case (n_phase)
                            wrt_pkg::PH_WORK: begin
                                n_relax_bar = '0;
                                n_need_div  = 1'b1;
                            end
                            wrt_pkg::PH_WORK_ON: begin
                                n_buzzer    = 1'b1;
                                n_relax_bar = '0;
                                n_work_bar  = BAR_FULL;
                                n_phase     = wrt_pkg::PH_WORK_OFF;
                            end
                            wrt_pkg::PH_WORK_OFF: begin
                                n_buzzer    = 1'b0;
                                n_relax_bar = '0;
                                n_work_bar  = '0;
                                n_phase     = wrt_pkg::PH_WORK_ON;
                            end
                            wrt_pkg::PH_RELAX: begin
                                n_work_bar  = '0;
                                n_need_div  = 1'b1;
                            end
                            wrt_pkg::PH_RELAX_ON: begin
                                n_buzzer    = 1'b1;
                                n_relax_bar = BAR_FULL;
                                n_work_bar  = '0;
                                n_phase     = wrt_pkg::PH_RELAX_OFF;
                            end
                            wrt_pkg::PH_RELAX_OFF: begin
                                n_buzzer    = 1'b0;
                                n_relax_bar = '0;
                                n_work_bar  = '0;
                                n_phase     = wrt_pkg::PH_RELAX_ON;
                            end
                            default: begin
                                n_phase = n_phase;
                            end
                        endcase
                    end
                end

                if (i_button_level) begin
                    if (r_integ > '0) begin
                        n_integ = r_integ - 1'b1;
                    end
                end else if (r_integ < wrt_pkg::INTEG_W'(wrt_pkg::INTEGRATOR_MAX)) begin
                    n_integ = r_integ + 1'b1;
                end
            end
        end
    end

    // one quotient bit per cycle while div_step is set
    assign trial    = {r_rem[wrt_pkg::TICK_W-1:0], r_quo[wrt_pkg::QUO_BITS-1]};
    assign trial_ge = trial >= {1'b0, period};

    // bar step from percentage
    always_comb begin
        if (period == '0) begin
            pct = wrt_pkg::PCT_FULL;
        end else if (r_quo > wrt_pkg::PCT_FULL) begin
            pct = wrt_pkg::PCT_FULL;
        end else begin
            pct = r_quo;
        end
        pct_m1 = pct - 1'b1;
        step   = '0;
        if (pct != '0) begin
            for (int k = 1; k < wrt_pkg::LED_COUNT; k++) begin
                if (pct_m1 >= wrt_pkg::PCT_W'(k * wrt_pkg::SEG_SIZE)) begin
                    step = wrt_pkg::STEP_W'(k);
                end
            end
        end
        bar_src = (r_phase == wrt_pkg::PH_WORK) ? r_work_bar : r_relax_bar;
        for (int i = 0; i < wrt_pkg::LED_COUNT; i++) begin
            if (wrt_pkg::STEP_W'(i) < step) begin
                bar_new[i] = 1'b0;
            end else if (wrt_pkg::STEP_W'(i) == step) begin
                bar_new[i] = ~bar_src[i];
            end else begin
                bar_new[i] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_work_ticks  <= wrt_pkg::WORK_TICKS_RST;
            r_relax_ticks <= wrt_pkg::RELAX_TICKS_RST;
            r_phase       <= wrt_pkg::PH_RELAX_ON;
            r_elapsed     <= '0;
            r_bdiv        <= '0;
            r_ddiv        <= '0;
            r_integ       <= '0;
            r_pressed     <= 1'b0;
            r_hold        <= '0;
            r_sleeping    <= 1'b0;
            r_work_bar    <= '0;
            r_relax_bar   <= '0;
            r_buzzer      <= 1'b0;
            r_halted      <= 1'b0;
            r_need_div    <= 1'b0;
            r_qcnt        <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == wrt_pkg::REG_WORK_TICKS) begin
                    r_work_ticks <= i_cfg_data;
                end
                if (i_cfg_idx == wrt_pkg::REG_RELAX_TICKS) begin
                    r_relax_ticks <= i_cfg_data;
                end
            end
            if (i_cmd.step) begin
                r_phase     <= n_phase;
                r_elapsed   <= n_elapsed;
                r_bdiv      <= n_bdiv;
                r_ddiv      <= n_ddiv;
                r_integ     <= n_integ;
                r_pressed   <= n_pressed;
                r_hold      <= n_hold;
                r_sleeping  <= n_sleeping;
                r_work_bar  <= n_work_bar;
                r_relax_bar <= n_relax_bar;
                r_buzzer    <= n_buzzer;
                r_halted    <= n_halted;
                r_need_div  <= n_need_div;
            end
            if (i_cmd.div_init) begin
                r_qcnt <= '0;
            end else if (i_cmd.div_step) begin
                r_qcnt <= r_qcnt + 1'b1;
            end
            if (i_cmd.bar_apply) begin
                if (r_phase == wrt_pkg::PH_WORK) begin
                    r_work_bar <= bar_new;
                end else begin
                    r_relax_bar <= bar_new;
                end
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.step) begin
            r_event <= n_event;
            r_enter <= n_enter;
        end
        if (i_cmd.load_mul) begin
            r_prod <= wrt_pkg::PROD_W'(r_elapsed) * wrt_pkg::PROD_W'(100);
        end
        if (i_cmd.div_init) begin
            r_rem <= {1'b0, r_prod[wrt_pkg::PROD_W-1:wrt_pkg::QUO_BITS]};
            r_quo <= r_prod[wrt_pkg::QUO_BITS-1:0];
        end else if (i_cmd.div_step) begin
            r_rem <= trial_ge ? trial - {1'b0, period} : trial;
            r_quo <= {r_quo[wrt_pkg::QUO_BITS-2:0], trial_ge};
        end
        if (i_cmd.emit) begin
            o_res.work_leds    <= 7'(r_work_bar);
            o_res.relax_leds   <= 7'(r_relax_bar);
            o_res.buzzer_on    <= r_buzzer;
            o_res.phase_now    <= r_phase;
            o_res.button_event <= r_event;
            o_res.sleep_enter  <= r_enter;
        end
    end

    assign o_res.valid    = r_out_valid;
    assign o_sts.need_div = r_need_div;
    assign o_sts.div_last = (r_qcnt == wrt_pkg::QCNT_W'(wrt_pkg::QUO_BITS - 1));
    assign o_sts.out_free = !r_out_valid || o_res.ready;

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
// Self-checking bench for work_relax_timer_with_debounce: random button ticks with
// bursty sender and stalling receiver, checked beat by beat against a tick predictor.
// Depends on wrt_pkg, wrt_in_if, wrt_out_if and the RTL top level.
`timescale 1ns / 100ps

module testbench;
    import wrt_pkg::*;

    localparam int STALL_LIMIT = 4000;
    localparam int HOLDOFF_CYCLES = 400;
    localparam int HOLDOFF_AFTER = 700;

    typedef struct packed {
        logic [6:0] work_leds;
        logic [6:0] relax_leds;
        logic       buzzer_on;
        t_phase     phase_now;
        t_event     button_event;
        logic       sleep_enter;
    } t_tick_res;

    typedef enum {RDY_ALWAYS, RDY_MOSTLY, RDY_RARELY, RDY_PATTERN} t_ready_mode;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [TICK_W-1:0]    cfg_data;

    wrt_in_if  btn_ch ();
    wrt_out_if res_ch ();

    work_relax_timer_with_debounce uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_btn      (btn_ch),
        .o_res      (res_ch)
    );

    // predictor state
    logic [TICK_W-1:0]  work_len, relax_len;
    t_phase             ph;
    logic [TICK_W-1:0]  ph_ticks;
    logic [BDIV_W-1:0]  btn_div;
    logic [DDIV_W-1:0]  disp_div;
    logic [INTEG_W-1:0] integ;
    logic               pressed_db;
    logic [HOLD_W-1:0]  hold_periods;
    logic               asleep;
    logic [6:0]         wbar, rbar;
    logic               buzz;
    logic               frozen;

    logic        tick_levels[$];
    t_tick_res   results_due[$];
    int          ticks_issued = 0;
    int          ticks_taken = 0;
    int          results_seen = 0;
    int          mismatches = 0;
    int          quiet_cycles = 0;
    logic        btn_taken = 1'b0;
    int          burst_left = 0;
    int          gap_left = 0;
    int          holdoff_left = 0;
    logic        holdoff_done = 1'b0;
    int          mode_left = 0;
    t_ready_mode ready_mode = RDY_ALWAYS;

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic logic [TICK_W-1:0] phase_length();
        return (ph <= PH_WORK_OFF) ? work_len : relax_len;
    endfunction

    function automatic logic [6:0] progress(input logic [6:0] bar);
        logic [TICK_W-1:0] len;
        int unsigned pct, step;
        len = phase_length();
        if (len == 0) begin
            pct = 100;
        end else begin
            pct = (32'(ph_ticks) * 32'd100) / 32'(len);
            if (pct > 100) pct = 100;
        end
        step = (pct == 0) ? 0 : (pct - 1) / SEG_SIZE;
        if (step > LED_COUNT - 1) step = LED_COUNT - 1;
        for (int i = 0; i < LED_COUNT; i++) begin
            if (i < step) bar[i] = 1'b0;
            else if (i == step) bar[i] = ~bar[i];
            else bar[i] = 1'b1;
        end
        return bar;
    endfunction

    function automatic t_tick_res snapshot(input t_event ev, input logic enter);
        t_tick_res r;
        r.work_leds    = wbar;
        r.relax_leds   = rbar;
        r.buzzer_on    = buzz;
        r.phase_now    = ph;
        r.button_event = ev;
        r.sleep_enter  = enter;
        return r;
    endfunction

    function automatic t_tick_res advance_tick(input logic level);
        t_event ev;
        ev = EV_NONE;
        if (frozen) return snapshot(EV_NONE, 1'b0);

        if (ph_ticks != TICK_MAX) ph_ticks++;
        if (ph_ticks >= phase_length()) begin
            ph_ticks = '0;
            if (!asleep) begin
                if (ph == PH_WORK) ph = PH_WORK_ON;
                else if (ph == PH_RELAX) ph = PH_RELAX_ON;
            end
        end

        btn_div++;
        if (btn_div >= BUTTON_PERIOD) begin
            btn_div = '0;
            if (integ == INTEGRATOR_MAX) begin
                ev = pressed_db ? EV_HELD : EV_PRESSED;
                if (hold_periods != HOLD_MAX) hold_periods++;
                pressed_db = 1'b1;
            end else if (integ == 0) begin
                ev = pressed_db ? EV_RELEASED : EV_NONE;
                hold_periods = '0;
                pressed_db = 1'b0;
            end
            if (ev == EV_RELEASED && asleep) begin
                frozen = 1'b1;
                return snapshot(ev, 1'b1);
            end
            if (ev == EV_HELD && hold_periods > HOLD_LIMIT) begin
                wbar = '0;
                rbar = '0;
                buzz = 1'b0;
                asleep = 1'b1;
            end
            if (ev == EV_PRESSED) begin
                if (ph == PH_WORK_ON || ph == PH_WORK_OFF) begin
                    buzz = 1'b0;
                    ph_ticks = '0;
                    ph = PH_RELAX;
                end else if (ph == PH_RELAX_ON || ph == PH_RELAX_OFF) begin
                    buzz = 1'b0;
                    ph_ticks = '0;
                    ph = PH_WORK;
                end
            end
        end

        disp_div++;
        if (disp_div >= DISPLAY_PERIOD) begin
            disp_div = '0;
            if (!asleep) begin
                case (ph)
                    PH_WORK: begin
                        rbar = '0;
                        wbar = progress(wbar);
                    end
                    PH_WORK_ON: begin
                        buzz = 1'b1;
                        rbar = '0;
                        wbar = '1;
                        ph = PH_WORK_OFF;
                    end
                    PH_WORK_OFF: begin
                        buzz = 1'b0;
                        rbar = '0;
                        wbar = '0;
                        ph = PH_WORK_ON;
                    end
                    PH_RELAX: begin
                        wbar = '0;
                        rbar = progress(rbar);
                    end
                    PH_RELAX_ON: begin
                        buzz = 1'b1;
                        rbar = '1;
                        wbar = '0;
                        ph = PH_RELAX_OFF;
                    end
                    PH_RELAX_OFF: begin
                        buzz = 1'b0;
                        rbar = '0;
                        wbar = '0;
                        ph = PH_RELAX_ON;
                    end
                    default: ;
                endcase
            end
        end

        if (level) begin
            if (integ != 0) integ--;
        end else if (integ != INTEGRATOR_MAX) begin
            integ++;
        end
        return snapshot(ev, 1'b0);
    endfunction

    task automatic report(input string msg);
        mismatches++;
        $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    // predict on accepted input beats, check result beats
    always @(posedge clk) begin : monitor
        t_tick_res want;
        btn_taken <= btn_ch.valid && btn_ch.ready;
        if (!rst_n) begin
            work_len = WORK_TICKS_RST;
            relax_len = RELAX_TICKS_RST;
            ph = PH_RELAX_ON;
            ph_ticks = '0;
            btn_div = '0;
            disp_div = '0;
            integ = '0;
            pressed_db = 1'b0;
            hold_periods = '0;
            asleep = 1'b0;
            wbar = '0;
            rbar = '0;
            buzz = 1'b0;
            frozen = 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_idx)
                    REG_WORK_TICKS:  work_len = cfg_data;
                    REG_RELAX_TICKS: relax_len = cfg_data;
                    default: ;
                endcase
            end
            if (btn_ch.valid && btn_ch.ready) begin
                ticks_taken++;
                results_due.push_back(advance_tick(btn_ch.button_level));
            end
            if (res_ch.valid && res_ch.ready) begin
                results_seen++;
                if (results_due.size() == 0) begin
                    report($sformatf("beat %0d arrived with nothing expected", results_seen));
                end else begin
                    want = results_due.pop_front();
                    if (res_ch.work_leds !== want.work_leds)
                        report($sformatf("beat %0d work_leds %h, want %h",
                                         results_seen, res_ch.work_leds, want.work_leds));
                    if (res_ch.relax_leds !== want.relax_leds)
                        report($sformatf("beat %0d relax_leds %h, want %h",
                                         results_seen, res_ch.relax_leds, want.relax_leds));
                    if (res_ch.buzzer_on !== want.buzzer_on)
                        report($sformatf("beat %0d buzzer_on %b, want %b",
                                         results_seen, res_ch.buzzer_on, want.buzzer_on));
                    if (res_ch.phase_now !== want.phase_now)
                        report($sformatf("beat %0d phase_now %0d, want %0d",
                                         results_seen, res_ch.phase_now, want.phase_now));
                    if (res_ch.button_event !== want.button_event)
                        report($sformatf("beat %0d button_event %0d, want %0d",
                                         results_seen, res_ch.button_event, want.button_event));
                    if (res_ch.sleep_enter !== want.sleep_enter)
                        report($sformatf("beat %0d sleep_enter %b, want %b",
                                         results_seen, res_ch.sleep_enter, want.sleep_enter));
                end
            end
        end
    end

    // sender: bursts of beats with random gaps
    always @(negedge clk) begin
        if (rst_n && !(btn_ch.valid && !btn_taken)) begin
            if (gap_left > 0) begin
                gap_left--;
                btn_ch.valid <= 1'b0;
            end else if (tick_levels.size() > 0) begin
                btn_ch.valid <= 1'b1;
                btn_ch.button_level <= tick_levels.pop_front();
                ticks_issued++;
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 30);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                end else begin
                    burst_left--;
                end
            end else begin
                btn_ch.valid <= 1'b0;
            end
        end
    end

    // receiver: stall pattern, plus one long hold-off
    always @(negedge clk) begin
        if (holdoff_left > 0) begin
            holdoff_left--;
            res_ch.ready <= 1'b0;
        end else if (!holdoff_done && ticks_taken >= HOLDOFF_AFTER) begin
            holdoff_done = 1'b1;
            holdoff_left = HOLDOFF_CYCLES;
            res_ch.ready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                ready_mode = t_ready_mode'($urandom_range(0, 3));
                mode_left = $urandom_range(20, 150);
            end else begin
                mode_left--;
            end
            case (ready_mode)
                RDY_ALWAYS: res_ch.ready <= 1'b1;
                RDY_MOSTLY: res_ch.ready <= ($urandom_range(0, 3) != 0);
                RDY_RARELY: res_ch.ready <= ($urandom_range(0, 3) == 0);
                default:    res_ch.ready <= (mode_left % 3 != 0);
            endcase
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (btn_ch.valid && btn_ch.ready) || (res_ch.valid && res_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("testbench failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic void queue_run(input logic lvl, input int n);
        repeat (n) tick_levels.push_back(lvl);
    endfunction

    function automatic void queue_bounce(input int n);
        repeat (n) tick_levels.push_back(1'($urandom_range(0, 1)));
    endfunction

    // mostly clean presses of bounded length, some noise and glitches
    function automatic void queue_activity(input int n);
        int stop;
        stop = tick_levels.size() + n;
        while (tick_levels.size() < stop) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5, 6: begin
                    queue_bounce($urandom_range(0, 4));
                    queue_run(1'b0, $urandom_range(6, 40));
                    queue_bounce($urandom_range(0, 4));
                    queue_run(1'b1, $urandom_range(6, 90));
                end
                7, 8: begin
                    queue_bounce($urandom_range(1, 12));
                    queue_run(1'b1, $urandom_range(6, 30));
                end
                default: begin
                    queue_run(1'b0, $urandom_range(1, 4));
                    queue_run(1'b1, $urandom_range(2, 20));
                end
            endcase
        end
    endfunction

    task automatic set_lengths(input logic [TICK_W-1:0] w_len, input logic [TICK_W-1:0] r_len);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_idx <= REG_WORK_TICKS;
        cfg_data <= w_len;
        @(negedge clk);
        cfg_idx <= REG_RELAX_TICKS;
        cfg_data <= r_len;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic settle();
        do @(negedge clk);
        while (tick_levels.size() != 0 || ticks_issued != ticks_taken || results_due.size() != 0);
    endtask

    initial begin
        logic [TICK_W-1:0] w_len, r_len;
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = '0;
        cfg_data = '0;
        btn_ch.valid = 1'b0;
        btn_ch.button_level = 1'b1;
        res_ch.ready = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // press out of the reset blink, release, bounce, short press
        set_lengths(5, 3);
        queue_run(1'b0, 8);
        queue_run(1'b1, 8);
        repeat (3) begin
            queue_run(1'b1, 1);
            queue_run(1'b0, 1);
        end
        queue_run(1'b0, 3);
        settle();

        for (int s = 0; s < 9; s++) begin
            case (s)
                0: begin w_len = '0; r_len = '0; end
                1: begin w_len = 1; r_len = 1; end
                2: begin w_len = 2; r_len = 7; end
                3: begin w_len = TICK_MAX; r_len = TICK_MAX; end
                4: begin
                    w_len = TICK_W'($urandom_range(3, 60));
                    r_len = TICK_W'($urandom_range(3, 60));
                end
                5: begin w_len = 100; r_len = 300; end
                6: begin
                    w_len = TICK_W'($urandom_range(150, 700));
                    r_len = TICK_W'($urandom_range(20, 200));
                end
                7: begin w_len = '0; r_len = TICK_W'($urandom_range(5, 50)); end
                default: begin w_len = TICK_W'($urandom_range(0, TICK_MAX)); r_len = '0; end
            endcase
            set_lengths(w_len, r_len);
            queue_activity(140);
            settle();
        end

        // long hold arms sleep, release powers down, then frozen
        set_lengths(40, 40);
        queue_run(1'b1, 10);
        queue_run(1'b0, 340);
        queue_run(1'b1, 10);
        queue_bounce(10);
        settle();

        repeat (16) @(posedge clk);
        if (mismatches == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule
